// File: rtl/core/dtsk_pkg.sv
`timescale 1ns / 1ps

package dtsk_pkg;

    localparam int MAX_FRAC_DIGITS_DEF = 10;

    localparam int FRAC_W = 60;
    localparam int CODE_W = 11;
    localparam int POS_W  = 4;
    localparam int SCAN_W = 64;
    localparam int LEN_W  = 7;

    localparam logic [FRAC_W-1:0] HALF_FX = FRAC_W'(1) << (FRAC_W - 1);

    // k = (x * K_RECIP) >> K_RECIP_SH - 200, x = p + 1206 < 4096
    localparam logic [11:0] K_RECIP    = 12'd2731;
    localparam int          K_RECIP_SH = 14;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_BIG_G = 8'h47;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    localparam logic [POS_W-1:0] POS_SIGN      = 4'd0;
    localparam logic [POS_W-1:0] POS_CODE_HI   = 4'd1;
    localparam logic [POS_W-1:0] POS_CODE_LO   = 4'd2;
    localparam logic [POS_W-1:0] POS_TILDE_END = 4'd12;

    typedef enum logic [1:0] {
        KIND_NUM,
        KIND_NAN,
        KIND_NEG_INF,
        KIND_TILDE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              sign;
        logic [CODE_W-1:0] code;
        logic [FRAC_W-1:0] frac;
    } key_entry_t;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_LZ_A,
        FS_LZ_B,
        FS_KDIV,
        FS_SHIFT,
        FS_RLZ_A,
        FS_RLZ_B,
        FS_ROUND,
        FS_PUSH
    } front_state_t;

    // Ordered base-64 alphabet: 0-9, A-Z, a-z, '|', '~'
    function automatic logic [7:0] b64_char(input logic [5:0] d);
        logic [7:0] c;
        if (d < 6'd10) begin
            c = 8'h30 + {2'b00, d};
        end else if (d < 6'd36) begin
            c = 8'h41 + {2'b00, d} - 8'd10;
        end else if (d < 6'd62) begin
            c = 8'h61 + {2'b00, d} - 8'd36;
        end else if (d == 6'd62) begin
            c = CH_BAR;
        end else begin
            c = CH_TILDE;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/dtsk_if.sv
`timescale 1ns / 1ps

interface dtsk_value_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;

    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

interface dtsk_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_char;
    logic       last_char;

    modport source (output valid, output key_char, output last_char, input ready);
    modport sink   (input valid, input key_char, input last_char, output ready);
endinterface

// File: rtl/core/double_to_sortable_key_unit.sv
`timescale 1ns / 1ps

// Turns each binary64 bit pattern into a memcmp-ordered ASCII key of 3 to 13
// bytes, one byte per cycle on key_ch while ready is high, with last_char marking
// the final byte. The front end runs a finite nonzero double through a
// leading-zero scan, the divide-by-six step, the alignment shift, a second
// leading-zero scan and the rounding, and passes zero, infinities and NaN
// straight to its push state; the back end emits one byte per cycle while
// key_ch.ready is high. A two-entry queue sits between them, so a new double
// is taken while the previous key is still going out.
module double_to_sortable_key_unit #(
    parameter int MAX_FRACTION_DIGITS = dtsk_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dtsk_value_if.sink value_ch,
    dtsk_key_if.source key_ch
);
    import dtsk_pkg::*;

    logic       fq_valid;
    logic       fq_ready;
    key_entry_t fq_entry;
    logic       qb_valid;
    logic       qb_ready;
    key_entry_t qb_entry;

    dtsk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_ch   (value_ch),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_entry (fq_entry)
    );

    dtsk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_entry (fq_entry),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_entry (qb_entry)
    );

    dtsk_back #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .take_valid (qb_valid),
        .take_ready (qb_ready),
        .take_entry (qb_entry),
        .key_ch     (key_ch)
    );

    // A new key starts only once the previous one has fully left
    a_key_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        (qb_valid && qb_ready) |-> (!key_ch.valid || (key_ch.ready && key_ch.last_char)))
        else $error("back end took a request in the middle of a key");

    // The front end takes a double only when it holds no pending request
    a_front_single: assert property (@(posedge clk) disable iff (!rst_n)
        (value_ch.valid && value_ch.ready) |-> !fq_valid)
        else $error("front end accepted a double while a request was pending");

    // Nonzero numbers: fraction lies above one half when positive, below when negative
    a_frac_side: assert property (@(posedge clk) disable iff (!rst_n)
        (qb_valid && qb_ready && (qb_entry.kind == KIND_NUM) && (qb_entry.code != '0))
        |-> (qb_entry.frac[FRAC_W-1] != qb_entry.sign))
        else $error("fraction on the wrong side of one half");

endmodule

// File: rtl/core/dtsk_front.sv
`timescale 1ns / 1ps

module dtsk_front (
    input  logic                 clk,
    input  logic                 rst_n,
    dtsk_value_if.sink           value_ch,
    output logic                 push_valid,
    input  logic                 push_ready,
    output dtsk_pkg::key_entry_t push_entry
);
    import dtsk_pkg::*;

    front_state_t      state_reg, state_next;
    logic              sign_reg;
    logic [10:0]       bexp_reg;
    logic [SCAN_W-1:0] scan_reg;
    logic [7:0]        nz_reg;
    logic [7:0][2:0]   clz_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [11:0]       x_reg;
    logic [8:0]        quot_reg;
    logic [CODE_W-1:0] code_reg;
    key_entry_t        entry_reg;

    logic [7:0]        nz_next;
    logic [7:0][2:0]   clz_next;
    logic [LEN_W-1:0]  bitlen;

    logic              in_sign;
    logic [10:0]       in_bexp;
    logic [51:0]       in_mant;
    logic              in_special;
    logic              in_zero;
    key_entry_t        special_entry;

    logic [11:0]       x_next;
    logic [23:0]       kprod;
    logic [11:0]       six_quot;
    logic [11:0]       rem_full;
    logic [LEN_W-1:0]  sh_full;
    logic [FRAC_W-1:0] r_val;
    logic [FRAC_W-1:0] sum_val;
    logic [CODE_W-1:0] code_next;

    logic [FRAC_W-1:0] rv;
    logic [2:0]        rnd_s;
    logic [FRAC_W:0]   rnd_mask;
    logic [FRAC_W:0]   rnd_low;
    logic [FRAC_W:0]   rnd_half;
    logic [FRAC_W:0]   rnd_ulp;
    logic              rnd_up;
    logic [FRAC_W:0]   f_val;
    key_entry_t        round_entry;

    function automatic logic [2:0] lz8(input logic [7:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int j = 0; j < 8; j++) begin
            if (v[j]) begin
                n = 3'(7 - j);
            end
        end
        return n;
    endfunction

    // First half of the leading-zero scan: per-byte flags and counts
    always_comb
    begin
        for (int i = 0; i < 8; i++) begin
            nz_next[i]  = |scan_reg[8*i +: 8];
            clz_next[i] = lz8(scan_reg[8*i +: 8]);
        end
    end

    // Second half: highest nonzero byte decides the bit length
    always_comb
    begin
        bitlen = '0;
        for (int i = 0; i < 8; i++) begin
            if (nz_reg[i]) begin
                bitlen = LEN_W'(8 * i + 8) - LEN_W'(clz_reg[i]);
            end
        end
    end

    // Classify the incoming request
    always_comb
    begin
        in_sign    = value_ch.value_bits[63];
        in_bexp    = value_ch.value_bits[62:52];
        in_mant    = value_ch.value_bits[51:0];
        in_special = &in_bexp;
        in_zero    = (in_bexp == 11'd0) && (in_mant == 52'd0);

        special_entry      = '0;
        special_entry.kind = KIND_NUM;
        special_entry.frac = HALF_FX;
        if (in_special) begin
            if (in_mant != 52'd0) begin
                special_entry.kind = KIND_NAN;
            end else if (in_sign) begin
                special_entry.kind = KIND_NEG_INF;
            end else begin
                special_entry.kind = KIND_TILDE;
            end
        end
    end

    // Exponent split: x = p + 1206, k = x / 6 - 200, q = x % 6 - 6
    always_comb
    begin
        if (bexp_reg == 11'd0) begin
            x_next = 12'(bitlen) + 12'd132;
        end else begin
            x_next = 12'(bitlen) + 12'(bexp_reg) + 12'd131;
        end
        kprod    = 24'(x_reg) * 24'(K_RECIP);
        six_quot = 12'(quot_reg) * 12'd6;
        rem_full = x_reg - six_quot;
        sh_full  = LEN_W'(54) + LEN_W'(rem_full[2:0]) - len_reg;
        r_val    = FRAC_W'(scan_reg[52:0]) << sh_full[5:0];
        sum_val  = sign_reg ? (HALF_FX - r_val) : (HALF_FX + r_val);
        code_next = sign_reg ? (CODE_W'(1224) - CODE_W'(quot_reg))
                             : (CODE_W'(824) + CODE_W'(quot_reg));
    end

    // Round to 53 significant bits, ties to even
    always_comb
    begin
        rv       = scan_reg[FRAC_W-1:0];
        rnd_s    = 3'(len_reg - LEN_W'(53));
        rnd_ulp  = (FRAC_W+1)'(1) << rnd_s;
        rnd_mask = rnd_ulp - (FRAC_W+1)'(1);
        rnd_half = rnd_ulp >> 1;
        rnd_low  = {1'b0, rv} & rnd_mask;
        rnd_up   = (rnd_low > rnd_half) || ((rnd_low == rnd_half) && rv[rnd_s]);
        if (len_reg > LEN_W'(53)) begin
            f_val = ({1'b0, rv} & ~rnd_mask) + (rnd_up ? rnd_ulp : '0);
        end else begin
            f_val = {1'b0, rv};
        end

        round_entry      = '0;
        round_entry.sign = sign_reg;
        round_entry.code = code_reg;
        round_entry.frac = f_val[FRAC_W-1:0];
        round_entry.kind = f_val[FRAC_W] ? KIND_TILDE : KIND_NUM;
    end

    always_comb
    begin
        state_next     = state_reg;
        value_ch.ready = 1'b0;
        push_valid     = 1'b0;
        unique case (state_reg)
            FS_IDLE:
            begin
                value_ch.ready = 1'b1;
                if (value_ch.valid) begin
                    state_next = (in_special || in_zero) ? FS_PUSH : FS_LZ_A;
                end
            end
            FS_LZ_A:  state_next = FS_LZ_B;
            FS_LZ_B:  state_next = FS_KDIV;
            FS_KDIV:  state_next = FS_SHIFT;
            FS_SHIFT: state_next = FS_RLZ_A;
            FS_RLZ_A: state_next = FS_RLZ_B;
            FS_RLZ_B: state_next = FS_ROUND;
            FS_ROUND: state_next = FS_PUSH;
            FS_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = FS_IDLE;
                end
            end
            default:  state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            FS_IDLE:
            begin
                sign_reg  <= in_sign;
                bexp_reg  <= in_bexp;
                scan_reg  <= {11'd0, (in_bexp != 11'd0), in_mant};
                entry_reg <= special_entry;
            end
            FS_LZ_A, FS_RLZ_A:
            begin
                nz_reg  <= nz_next;
                clz_reg <= clz_next;
            end
            FS_LZ_B:
            begin
                len_reg <= bitlen;
                x_reg   <= x_next;
            end
            FS_KDIV:
            begin
                quot_reg <= kprod[K_RECIP_SH +: 9];
            end
            FS_SHIFT:
            begin
                scan_reg <= SCAN_W'(sum_val);
                code_reg <= code_next;
            end
            FS_RLZ_B:
            begin
                len_reg <= bitlen;
            end
            FS_ROUND:
            begin
                entry_reg <= round_entry;
            end
            default:
            begin
            end
        endcase
    end

    assign push_entry = entry_reg;

endmodule

// File: rtl/core/dtsk_queue.sv
`timescale 1ns / 1ps

module dtsk_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  dtsk_pkg::key_entry_t wr_entry,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output dtsk_pkg::key_entry_t rd_entry
);
    import dtsk_pkg::*;

    key_entry_t mem [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       wr_fire;
    logic       rd_fire;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 2'(wr_fire) - 2'(rd_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (wr_fire) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_fire) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// File: rtl/core/dtsk_back.sv
`timescale 1ns / 1ps

module dtsk_back #(
    parameter int MAX_FRACTION_DIGITS = dtsk_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take_valid,
    output logic                 take_ready,
    input  dtsk_pkg::key_entry_t take_entry,
    dtsk_key_if.source           key_ch
);
    import dtsk_pkg::*;

    localparam logic [POS_W-1:0] POS_FRAC_END = POS_W'(MAX_FRACTION_DIGITS + 2);

    logic              busy_reg;
    kind_t             kind_reg;
    logic              sign_reg;
    logic [CODE_W-1:0] code_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [POS_W-1:0]  pos_reg;

    logic [7:0]        char_val;
    logic              last_val;
    logic              out_fire;
    logic              take_fire;

    always_comb
    begin
        char_val = CH_ZERO;
        last_val = 1'b0;
        unique case (kind_reg)
            KIND_NAN:
            begin
                char_val = (pos_reg == POS_CODE_HI) ? CH_BIG_G : CH_ZERO;
                last_val = (pos_reg == POS_CODE_LO);
            end
            KIND_NEG_INF:
            begin
                if (pos_reg == POS_SIGN) begin
                    char_val = CH_MINUS;
                end else if (pos_reg == POS_CODE_HI) begin
                    char_val = CH_ZERO;
                end else begin
                    char_val = CH_ONE;
                end
                last_val = (pos_reg == POS_CODE_LO);
            end
            KIND_TILDE:
            begin
                char_val = (pos_reg == POS_SIGN) ? CH_ZERO : CH_TILDE;
                last_val = (pos_reg == POS_TILDE_END);
            end
            KIND_NUM:
            begin
                if (pos_reg == POS_SIGN) begin
                    char_val = sign_reg ? CH_MINUS : CH_ZERO;
                end else if (pos_reg == POS_CODE_HI) begin
                    char_val = b64_char({1'b0, code_reg[10:6]});
                end else if (pos_reg == POS_CODE_LO) begin
                    char_val = b64_char(code_reg[5:0]);
                    last_val = (frac_reg == '0);
                end else begin
                    char_val = b64_char(frac_reg[FRAC_W-1 -: 6]);
                    last_val = (frac_reg[FRAC_W-7:0] == '0) || (pos_reg == POS_FRAC_END);
                end
            end
        endcase
    end

    assign key_ch.valid     = busy_reg;
    assign key_ch.key_char  = char_val;
    assign key_ch.last_char = last_val;

    assign out_fire   = busy_reg && key_ch.ready;
    // Take the next request when idle or as the last byte of the current key leaves
    assign take_ready = !busy_reg || (out_fire && last_val);
    assign take_fire  = take_valid && take_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else begin
            if (take_fire) begin
                busy_reg <= 1'b1;
                pos_reg  <= POS_SIGN;
            end else if (out_fire) begin
                if (last_val) begin
                    busy_reg <= 1'b0;
                end else begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_fire) begin
            kind_reg <= take_entry.kind;
            sign_reg <= take_entry.sign;
            code_reg <= take_entry.code;
            frac_reg <= take_entry.frac;
        end else if (out_fire && (pos_reg > POS_CODE_LO)) begin
            frac_reg <= {frac_reg[FRAC_W-7:0], 6'd0};
        end
    end

endmodule

// File: tb/sortable_key_checker.sv
`timescale 1ns / 1ps

module sortable_key_checker #(
    parameter int MAX_DIGITS = dtsk_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    dtsk_value_if value_ch,
    dtsk_key_if   key_ch,
    output int    mismatches,
    output int    outstanding
);

    import dtsk_pkg::*;

    localparam logic [63:0] FX_HALF = 64'd1 << 59;
    localparam logic [63:0] FX_ONE  = 64'd1 << 60;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } key_byte_t;

    key_byte_t key_q[$];
    key_byte_t want;
    int        errs = 0;
    int        pending_n = 0;

    assign mismatches  = errs;
    assign outstanding = pending_n;

    function automatic int bit_len(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    // Keep the top 53 significant bits, nearest, ties to even.
    function automatic logic [63:0] round_to_53(input logic [63:0] v);
        int          b;
        int          s;
        logic [63:0] low;
        logic [63:0] half;
        logic [63:0] kept;
        b = bit_len(v);
        if (b <= 53) begin
            return v;
        end
        s    = b - 53;
        low  = v & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 1);
        kept = v >> s;
        if (low > half || (low == half && kept[0])) begin
            kept = kept + 64'd1;
        end
        return kept << s;
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        string alphabet;
        alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz|~";
        return alphabet[d];
    endfunction

    task automatic predict_key(input logic [63:0] bits);
        logic        neg;
        logic [10:0] bexp;
        logic [51:0] frac_in;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] f;
        logic [10:0] code;
        int          e2;
        int          len;
        int          p;
        int          k;
        int          q;
        int          sh;
        int          cnt;
        logic [7:0]  chars[$];
        neg     = bits[63];
        bexp    = bits[62:52];
        frac_in = bits[51:0];
        code    = '0;
        f       = '0;
        if (bexp == 11'h7ff) begin
            if (frac_in != '0) begin
                chars = '{CH_ZERO, CH_BIG_G, CH_ZERO};
            end else if (neg) begin
                chars = '{CH_MINUS, CH_ZERO, CH_ONE};
            end else begin
                chars.push_back(CH_ZERO);
                repeat (12) chars.push_back(CH_TILDE);
            end
        end else begin
            if (bexp == '0 && frac_in == '0) begin
                chars.push_back(CH_ZERO);
                f = FX_HALF;
            end else begin
                if (bexp == '0) begin
                    m  = {12'd0, frac_in};
                    e2 = -1074;
                end else begin
                    m  = {11'd0, 1'b1, frac_in};
                    e2 = int'(bexp) - 1075;
                end
                // pick k so that |x| / 64^k lands in [1/128, 1/2)
                len = bit_len(m);
                p   = len + e2;
                k   = (p + 1206) / 6 - 200;
                q   = p - 6 * k;
                sh  = q - len + 60;
                r   = m << sh;
                chars.push_back(neg ? CH_MINUS : CH_ZERO);
                f = round_to_53(neg ? FX_HALF - r : FX_HALF + r);
                if (f >= FX_ONE) begin
                    repeat (12) chars.push_back(CH_TILDE);
                end else begin
                    code = neg ? 11'(1024 - k) : 11'(1024 + k);
                end
            end
            if (f < FX_ONE) begin
                chars.push_back(digit_char({1'b0, code[10:6]}));
                chars.push_back(digit_char(code[5:0]));
                cnt = 0;
                while (f != '0 && cnt < MAX_DIGITS) begin
                    chars.push_back(digit_char(f[59:54]));
                    f   = {4'd0, f[53:0], 6'd0};
                    cnt = cnt + 1;
                end
            end
        end
        foreach (chars[i]) begin
            key_q.push_back('{ch: chars[i], last: (i == chars.size() - 1)});
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (value_ch.valid && value_ch.ready) begin
                predict_key(value_ch.value_bits);
            end
            if (key_ch.valid && key_ch.ready) begin
                if (key_q.size() == 0) begin
                    errs = errs + 1;
                    if (errs <= 10) begin
                        $display("[%0t] unexpected key byte %h last %b", $realtime,
                                 key_ch.key_char, key_ch.last_char);
                    end
                end else begin
                    want = key_q.pop_front();
                    if (want.ch !== key_ch.key_char || want.last !== key_ch.last_char) begin
                        errs = errs + 1;
                        if (errs <= 10) begin
                            $display("[%0t] key byte mismatch: expected %h last %b, got %h last %b",
                                     $realtime, want.ch, want.last,
                                     key_ch.key_char, key_ch.last_char);
                        end
                    end
                end
            end
            pending_n = key_q.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   keys_pending;
    int   cycles;
    bit   hold_off_req = 1'b0;
    bit   hold_off_done = 1'b0;

    logic [63:0] corner_vals [24] = '{
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000,
        64'h7ff8_0000_0000_0000, 64'h7ff0_0000_0000_0001,
        64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0001,
        64'h8000_0000_0000_0001, 64'h000f_ffff_ffff_ffff,
        64'h0010_0000_0000_0000, 64'h7fef_ffff_ffff_ffff,
        64'hffef_ffff_ffff_ffff, 64'h3ff0_0000_0000_0000,
        64'hbff0_0000_0000_0000, 64'h3fe0_0000_0000_0000,
        64'h3fdf_ffff_ffff_ffff, 64'hbfdf_ffff_ffff_ffff,
        64'h4050_0000_0000_0000, 64'hc050_0000_0000_0000,
        64'h3ff0_0000_0000_0001, 64'h0123_4567_89ab_cdef,
        64'hc2e0_1234_5678_9abc, 64'h3f7f_ffff_ffff_ffff
    };

    dtsk_value_if value_ch ();
    dtsk_key_if   key_ch ();

    double_to_sortable_key_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_ch),
        .key_ch   (key_ch)
    );

    sortable_key_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_ch    (value_ch),
        .key_ch      (key_ch),
        .mismatches  (mismatch_count),
        .outstanding (keys_pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly short gaps, now and then a long one, half the time none
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] random_double();
        int          sel;
        logic        sgn;
        logic [10:0] bexp;
        logic [63:0] raw;
        sel  = $urandom_range(0, 99);
        sgn  = 1'($urandom_range(0, 1));
        raw  = {$urandom, $urandom};
        bexp = 11'($urandom_range(1, 2046));
        if (sel < 15) begin
            bexp = 11'($urandom_range(983, 1063));
        end else if (sel < 23) begin
            // subnormal with a random number of leading zeros
            bexp = '0;
            raw  = raw >> $urandom_range(12, 63);
        end else if (sel < 31) begin
            // fraction near all ones: the rounding-to-one cases live here
            raw[51:0] = 52'hf_ffff_ffff_ffff - 52'($urandom_range(0, 3));
        end else if (sel < 35) begin
            bexp = '0;
            raw  = '0;
        end else if (sel < 40) begin
            bexp = 11'h7ff;
            if ($urandom_range(0, 1) == 0) begin
                raw = '0;
            end
        end else if (sel < 50) begin
            return {$urandom, $urandom};
        end
        return {sgn, bexp, raw[51:0]};
    endfunction

    task automatic send_value(input logic [63:0] bits, input int gap);
        value_ch.valid      <= 1'b1;
        value_ch.value_bits <= bits;
        @(posedge clk);
        while (!value_ch.ready) @(posedge clk);
        @(negedge clk);
        if (gap > 0) begin
            value_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        key_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done) begin
                key_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_done = 1'b1;
                key_ch.ready <= 1'b1;
            end else begin
                int stall;
                stall = pick_gap();
                if (stall > 0) begin
                    key_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                key_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles = cycles + 1;
        end
        $display("** double_to_sortable_key_unit: FAILED **");
        $finish;
    end

    initial begin
        value_ch.valid      = 1'b0;
        value_ch.value_bits = '0;
        rst_n               = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (corner_vals[i]) begin
            send_value(corner_vals[i], pick_gap());
        end
        repeat (120) send_value(random_double(), pick_gap());

        // drain: hold the sender until every key is out
        send_value(random_double(), 1);
        while (keys_pending != 0) @(negedge clk);

        // back-to-back requests while the receiver holds off
        hold_off_req = 1'b1;
        repeat (40) send_value(random_double(), 0);

        repeat (149) send_value(random_double(), pick_gap());
        value_ch.valid <= 1'b0;

        while (keys_pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("** double_to_sortable_key_unit: PASSED **");
        end else begin
            $display("** double_to_sortable_key_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: double_to_sortable_key_unit.f
rtl/core/dtsk_pkg.sv
rtl/core/dtsk_if.sv
rtl/core/dtsk_front.sv
rtl/core/dtsk_queue.sv
rtl/core/dtsk_back.sv
rtl/core/double_to_sortable_key_unit.sv
tb/sortable_key_checker.sv
tb/tb.sv
